[hdl/ptt_pkg.sv]
// Shared codes, field widths and the result record of the periodic timer table.
// No dependencies; imported by periodic_timer_table_core and tb_top.
package ptt_pkg;

    // Field widths of the stream payloads
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int IVAL_W     = 31;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;   // slot + interval_ms, padded to whole bytes
    localparam int OUT_DATA_W = 8;    // slot_out + status, padded to whole bytes

    // Operation codes carried in s_tuser
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESET  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

endpackage

[hdl/periodic_timer_table_core.sv]
// Periodic timer table: time counter, per-slot valid flags, and period and
// last-fire memories with a sequencer for add searches and scans.
// Depends on ptt_pkg.
//
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+---------------------------------------------
// s_*      | in  | s_tvalid/tready  | tuser: kind; tdata: slot, interval_ms
// m_*      | out | m_tvalid/tready  | tuser: fired; tdata: slot_out, status; tlast
//
// Tick only advances the time counter. Change, reset and remove pass through the
// emit state. Add searches the slots in order in the add state, then emits its
// result, or a full status if no slot is free.
// Scan visits every slot in order: a valid slot is read from memory, then
// compared and written back; a free slot is skipped; a closing result follows.
// Reset clears the counter, the valid flags and the sequencer; the memories
// hold nothing meaningful until a slot is added. A stalled m_tready holds the
// sequencer at the next result; s_tready is high whenever the sequencer is idle.
module periodic_timer_table_core #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] slot, [34:4] interval_ms, [39:35] zero
    input  logic [ptt_pkg::IN_DATA_W-1:0]   s_tdata,
    // [2:0] kind
    input  logic [ptt_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] slot_out, [5:4] status, [7:6] zero
    output logic [ptt_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] fired
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import ptt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD      = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CMP = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [TIME_BITS-1:0] ival_reg, ival_next;
    result_t              pend_reg, pend_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0] period_rd_reg, last_fire_rd_reg;

    logic [TIME_BITS-1:0] period_mem    [NUM_SLOTS];
    logic [TIME_BITS-1:0] last_fire_mem [NUM_SLOTS];

    logic                 period_we, last_fire_we;
    logic [IDX_W-1:0]     period_wa, last_fire_wa;
    logic [TIME_BITS-1:0] period_wd, last_fire_wd;

    logic [SLOT_W-1:0]          in_slot;
    logic [IVAL_W-1:0]          in_ival_raw;
    logic [IDX_W+SLOT_W-1:0]    in_slot_ext;
    logic [IDX_W-1:0]           in_idx;
    logic                       in_range;
    logic [TIME_BITS+IVAL_W-1:0] in_ival_ext;
    logic [TIME_BITS-1:0]       in_ival;
    logic [IDX_W+SLOT_W-1:0]    idx_ext;
    logic [SLOT_W-1:0]          idx_slot;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       due;
    logic                       out_free;
    logic                       in_xfer;

    // Input unpacking and width adaption
    assign in_slot     = s_tdata[SLOT_W-1:0];
    assign in_ival_raw = s_tdata[SLOT_W+IVAL_W-1:SLOT_W];
    assign in_slot_ext = {{IDX_W{1'b0}}, in_slot};
    assign in_idx      = in_slot_ext[IDX_W-1:0];
    assign in_range    = (int'(in_slot) < NUM_SLOTS);
    assign in_ival_ext = {{TIME_BITS{1'b0}}, in_ival_raw};
    assign in_ival     = in_ival_ext[TIME_BITS-1:0];
    assign idx_ext     = {{SLOT_W{1'b0}}, idx_reg};
    assign idx_slot    = idx_ext[SLOT_W-1:0];

    assign elapsed  = now_reg - last_fire_rd_reg;
    assign due      = (elapsed > period_rd_reg);
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.slot};
    assign m_tuser  = out_reg.fired;
    assign m_tlast  = out_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        now_next       = now_reg;
        valid_next     = valid_reg;
        ival_next      = ival_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        period_we      = 1'b0;
        period_wa      = idx_reg;
        period_wd      = ival_reg;
        last_fire_we   = 1'b0;
        last_fire_wa   = idx_reg;
        last_fire_wd   = now_reg - ival_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ival_next      = in_ival;
                    idx_next       = '0;
                    pend_next.slot = in_slot;
                    pend_next.fired  = 1'b0;
                    pend_next.status = STATUS_OK;
                    pend_next.last   = 1'b1;
                    unique case (s_tuser) inside
                        KIND_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        KIND_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        KIND_CHANGE, KIND_RESET, KIND_REMOVE:
                        begin
                            state_next = ST_EMIT;
                            if (!in_range || !valid_reg[in_idx])
                            begin
                                pend_next.status = STATUS_NO_ENTRY;
                            end
                            else if (s_tuser == KIND_CHANGE)
                            begin
                                period_we = 1'b1;
                                period_wa = in_idx;
                                period_wd = in_ival;
                            end
                            else if (s_tuser == KIND_RESET)
                            begin
                                last_fire_we = 1'b1;
                                last_fire_wa = in_idx;
                                last_fire_wd = now_reg;
                            end
                            else
                            begin
                                valid_next[in_idx] = 1'b0;
                            end
                        end
                        KIND_SCAN:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            // unknown kind: drop the transfer
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    period_we           = 1'b1;
                    last_fire_we        = 1'b1;
                    pend_next.slot      = idx_slot;
                    state_next          = ST_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    pend_next.slot   = '0;
                    pend_next.status = STATUS_FULL;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                // memories read at idx_reg on this edge
                if (valid_reg[idx_reg])
                begin
                    state_next = ST_SCAN_CMP;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    pend_next.slot = '0;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_CMP:
            begin
                if (!due || out_free)
                begin
                    if (due)
                    begin
                        last_fire_we         = 1'b1;
                        last_fire_wd         = last_fire_rd_reg + period_rd_reg;
                        out_next.slot        = idx_slot;
                        out_next.fired       = 1'b1;
                        out_next.status      = STATUS_OK;
                        out_next.last        = 1'b0;
                        out_valid_next       = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        pend_next.slot = '0;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            now_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ival_reg <= ival_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Timer memories: one write port each, registered read at the sequencer index
    always_ff @(posedge clk)
    begin
        if (period_we)
        begin
            period_mem[period_wa] <= period_wd;
        end
        if (last_fire_we)
        begin
            last_fire_mem[last_fire_wa] <= last_fire_wd;
        end
        period_rd_reg    <= period_mem[idx_reg];
        last_fire_rd_reg <= last_fire_mem[idx_reg];
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_table_core: a queue-fed stream driver,
// an in-line prediction of the timer table, and a result monitor on the output stream.
// Depends on ptt_pkg and periodic_timer_table_core.
module tb_top;

    import ptt_pkg::*;

    localparam int NSLOTS       = 16;
    localparam int TIME_W       = 32;
    localparam int N_RAND_OPS   = 380;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * NSLOTS + 8;
    localparam int LONG_HOLD    = 400;

    // Kinds the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [IVAL_W-1:0] ival;
    } timer_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    // Predicted table state
    logic [TIME_W-1:0] now_ms;
    logic              slot_used [NSLOTS];
    logic [TIME_W-1:0] slot_ival [NSLOTS];
    logic [TIME_W-1:0] slot_fired_at [NSLOTS];

    timer_op_t op_q[$];
    result_t   pending_results[$];
    timer_op_t cur_op;
    bit        holding = 0;
    bit        draining = 0;
    int        errors = 0;
    int        rx_count = 0;
    int        cycle_cnt = 0;

    periodic_timer_table_core #(
        .NUM_SLOTS (NSLOTS),
        .TIME_BITS (TIME_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic result_t make_result(logic [SLOT_W-1:0] slot, logic fired,
                                            logic [STATUS_W-1:0] status, logic last);
        result_t r;
        r.slot   = slot;
        r.fired  = fired;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // Apply one accepted operation to the predicted table and queue its results
    task automatic apply_timer_op(timer_op_t op);
        logic [TIME_W-1:0] ival;
        logic [TIME_W-1:0] elapsed;
        bit                placed;
        ival   = TIME_W'(op.ival);
        placed = 0;
        case (op.kind)
            KIND_TICK: now_ms = now_ms + 1;
            KIND_ADD:
            begin
                for (int s = 0; s < NSLOTS; s++)
                begin
                    if (!placed && !slot_used[s])
                    begin
                        placed           = 1;
                        slot_used[s]     = 1'b1;
                        slot_ival[s]     = ival;
                        slot_fired_at[s] = now_ms - ival;
                        pending_results.push_back(make_result(SLOT_W'(s), 1'b0, STATUS_OK, 1'b1));
                    end
                end
                if (!placed)
                    pending_results.push_back(make_result('0, 1'b0, STATUS_FULL, 1'b1));
            end
            KIND_CHANGE, KIND_RESET, KIND_REMOVE:
            begin
                if (!slot_used[op.slot])
                    pending_results.push_back(make_result(op.slot, 1'b0, STATUS_NO_ENTRY, 1'b1));
                else
                begin
                    if (op.kind == KIND_CHANGE)
                        slot_ival[op.slot] = ival;
                    else if (op.kind == KIND_RESET)
                        slot_fired_at[op.slot] = now_ms;
                    else
                        slot_used[op.slot] = 1'b0;
                    pending_results.push_back(make_result(op.slot, 1'b0, STATUS_OK, 1'b1));
                end
            end
            KIND_SCAN:
            begin
                for (int s = 0; s < NSLOTS; s++)
                begin
                    elapsed = now_ms - slot_fired_at[s];
                    // a due slot fires once per scan however far behind it is
                    if (slot_used[s] && elapsed > slot_ival[s])
                    begin
                        slot_fired_at[s] = slot_fired_at[s] + slot_ival[s];
                        pending_results.push_back(make_result(SLOT_W'(s), 1'b1, STATUS_OK, 1'b0));
                    end
                end
                pending_results.push_back(make_result('0, 1'b0, STATUS_OK, 1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic push_op(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                           logic [IVAL_W-1:0] ival);
        timer_op_t op;
        op.kind = kind;
        op.slot = slot;
        op.ival = ival;
        op_q.push_back(op);
    endtask

    // Mostly short periods so that timers actually fall due
    function automatic logic [IVAL_W-1:0] rand_ival();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return {IVAL_W{1'b1}};
        else if (r < 3)
            return IVAL_W'($urandom());
        else
            return IVAL_W'($urandom_range(0, 8));
    endfunction

    // Driver: take the transfer at the rising edge, present the next item at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            apply_timer_op(cur_op);
            holding = 0;
        end
    end

    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && !holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (op_q.size() > 0)
            begin
                cur_op = op_q.pop_front();
                holding = 1;
                s_tuser  <= cur_op.kind;
                s_tdata  <= {{(IN_DATA_W - SLOT_W - IVAL_W){1'b0}}, cur_op.ival, cur_op.slot};
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall in modes of random length, plus one long hold-off
    int  hold_left = 0;
    int  mode = 0;
    int  mode_left = 0;
    bit  long_hold_done = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (draining)
                m_tready <= 1'b1;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && rx_count >= 120)
            begin
                long_hold_done = 1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: slot_out %0d fired %0b status %0d last %0b",
                       m_tdata[SLOT_W-1:0], m_tuser, m_tdata[SLOT_W+STATUS_W-1:SLOT_W], m_tlast);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tdata[SLOT_W-1:0] !== exp_r.slot)
                begin
                    $error("slot_out: expected %0d, got %0d", exp_r.slot, m_tdata[SLOT_W-1:0]);
                    errors++;
                end
                if (m_tuser !== exp_r.fired)
                begin
                    $error("fired: expected %0b, got %0b", exp_r.fired, m_tuser);
                    errors++;
                end
                if (m_tdata[SLOT_W+STATUS_W-1:SLOT_W] !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status,
                           m_tdata[SLOT_W+STATUS_W-1:SLOT_W]);
                    errors++;
                end
                if (m_tlast !== exp_r.last)
                begin
                    $error("last: expected %0b, got %0b", exp_r.last, m_tlast);
                    errors++;
                end
                if (m_tdata[OUT_DATA_W-1:SLOT_W+STATUS_W] !== '0)
                begin
                    $error("tdata padding: expected 0, got %0h",
                           m_tdata[OUT_DATA_W-1:SLOT_W+STATUS_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int n_ops;
        int r;
        logic [IVAL_W-1:0] ival;

        now_ms = '0;
        for (int s = 0; s < NSLOTS; s++)
        begin
            slot_used[s]     = 1'b0;
            slot_ival[s]     = '0;
            slot_fired_at[s] = '0;
        end

        // Directed: empty table, operations on free slots, fill past full
        push_op(KIND_SCAN, '0, '0);
        push_op(KIND_CHANGE, 4'd3, 31'd7);
        push_op(KIND_REMOVE, 4'd15, '0);
        for (int i = 0; i <= NSLOTS; i++)
        begin
            case (i)
                0:       ival = '0;
                1:       ival = {IVAL_W{1'b1}};
                2:       ival = 31'd1;
                3:       ival = 31'h2AAA_AAAA;
                4:       ival = 31'h5555_5555;
                default: ival = IVAL_W'(i % 4);
            endcase
            push_op(KIND_ADD, 4'(i), ival);
        end
        // one tick makes every slot due: the scan reports all of them
        push_op(KIND_TICK, '0, '0);
        push_op(KIND_SCAN, '0, '0);
        push_op(KIND_CHANGE, 4'd5, 31'd3);
        push_op(KIND_RESET, 4'd7, '0);
        push_op(KIND_REMOVE, 4'd9, '0);
        push_op(KIND_SPARE_A, 4'd2, 31'd2);

        // Random mix; ignored kinds do not count towards the total
        n_ops = 0;
        while (n_ops < N_RAND_OPS)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                push_op(KIND_TICK, 4'($urandom_range(0, 15)), rand_ival());
            else if (r < 44)
                push_op(KIND_ADD, 4'($urandom_range(0, 15)), rand_ival());
            else if (r < 54)
                push_op(KIND_CHANGE, 4'($urandom_range(0, 15)), rand_ival());
            else if (r < 62)
                push_op(KIND_RESET, 4'($urandom_range(0, 15)), rand_ival());
            else if (r < 74)
                push_op(KIND_REMOVE, 4'($urandom_range(0, 15)), rand_ival());
            else if (r < 98)
                push_op(KIND_SCAN, 4'($urandom_range(0, 15)), rand_ival());
            else
                push_op(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B,
                        4'($urandom_range(0, 15)), rand_ival());
            if (r < 98)
                n_ops++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_q.size() != 0 || holding || pending_results.size() != 0)
            @(posedge clk);
        // keep the output open long enough to catch any stray result
        draining = 1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
